FILE: hdl/ascii_to_hid_keystroke_encoder_defines.svh
// Assertion macros shared by the keystroke encoder RTL.
`ifndef ASCII_TO_HID_KEYSTROKE_ENCODER_DEFINES_SVH
`define ASCII_TO_HID_KEYSTROKE_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define A2H_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define A2H_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define A2H_ASSERT_NOW(lbl, ante, cons, msg)

`define A2H_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hdl/a2h_pkg.sv
// Shared types, keyword tables and HID usage constants for the keystroke encoder.
`timescale 1ns / 1ps

package a2h_pkg;

    localparam int PENDING_DEPTH = 4;
    localparam int WORK_DEPTH    = PENDING_DEPTH + 1;
    localparam int CNT_W         = $clog2(WORK_DEPTH + 1);
    localparam int IDX_W         = $clog2(WORK_DEPTH);
    localparam int NUM_WORDS     = 4;
    localparam int WORD_MAX      = 5;

    typedef logic [7:0]                  char_t;
    typedef logic [1:0]                  mod_t;
    typedef logic [CNT_W-1:0]            cnt_t;
    typedef logic [WORK_DEPTH-1:0][7:0]  work_buf_t;

    localparam mod_t MOD_NONE  = 2'd0;
    localparam mod_t SHIFT_MOD = 2'd2;

    localparam char_t USAGE_NONE  = 8'h00;
    localparam char_t USAGE_A     = 8'h04;
    localparam char_t USAGE_1     = 8'h1E;
    localparam char_t USAGE_0     = 8'h27;
    localparam char_t USAGE_ENTER = 8'h28;
    localparam char_t USAGE_SPACE = 8'h2C;

    localparam char_t WORD_TEXT [NUM_WORDS][WORD_MAX] = '{
        '{8'h55, 8'h50, 8'h00, 8'h00, 8'h00},   // UP
        '{8'h44, 8'h4F, 8'h57, 8'h4E, 8'h00},   // DOWN
        '{8'h4C, 8'h45, 8'h46, 8'h54, 8'h00},   // LEFT
        '{8'h52, 8'h49, 8'h47, 8'h48, 8'h54}    // RIGHT
    };
    localparam cnt_t  WORD_LEN   [NUM_WORDS] = '{cnt_t'(2), cnt_t'(4), cnt_t'(4), cnt_t'(5)};
    localparam char_t WORD_USAGE [NUM_WORDS] = '{8'h52, 8'h51, 8'h50, 8'h4F};

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_PREFIX = 2'd1,
        CLS_WORD   = 2'd2
    } cls_kind_t;

    typedef struct packed {
        cls_kind_t kind;
        char_t     usage;
    } cls_result_t;

    typedef struct packed {
        mod_t  modifier;
        char_t usage;
    } key_t;

endpackage

FILE: hdl/a2h_channels.sv
// Valid/ready channel interfaces for characters in and key reports out.
`timescale 1ns / 1ps

interface a2h_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_message;

    modport source (output valid, output char_code, output end_of_message, input ready);
    modport sink   (input valid, input char_code, input end_of_message, output ready);
endinterface

interface a2h_report_if;
    logic       valid;
    logic       ready;
    logic [1:0] modifier;
    logic [7:0] keycode;
    logic       last;

    modport source (output valid, output modifier, output keycode, output last, input ready);
    modport sink   (input valid, input modifier, input keycode, input last, output ready);
endinterface

FILE: hdl/a2h_classify.sv
// Keyword compare unit: matches the held characters against UP, DOWN, LEFT and RIGHT.
`timescale 1ns / 1ps

module a2h_classify
    import a2h_pkg::*;
(
    input  work_buf_t   chars,
    input  cnt_t        count,
    output cls_result_t result
);

    always_comb
    begin
        logic ok;
        result = '{kind: CLS_NONE, usage: USAGE_NONE};
        for (int w = 0; w < NUM_WORDS; w++)
        begin
            ok = (count <= WORD_LEN[w]);
            // Positions past the longest keyword never matter: a match needs count <= length.
            for (int i = 0; i < WORD_MAX; i++)
            begin
                if ((cnt_t'(i) < count) && (chars[i] != WORD_TEXT[w][i]))
                begin
                    ok = 1'b0;
                end
            end
            if (ok)
            begin
                if (count == WORD_LEN[w])
                begin
                    result.kind  = CLS_WORD;
                    result.usage = WORD_USAGE[w];
                end
                else if (result.kind == CLS_NONE)
                begin
                    result.kind = CLS_PREFIX;
                end
            end
        end
    end

endmodule

FILE: hdl/a2h_keymap.sv
// Maps one ASCII character to its HID boot-keyboard usage and modifier.
`timescale 1ns / 1ps

module a2h_keymap
    import a2h_pkg::*;
(
    input  char_t ch,
    output key_t  key
);

    always_comb
    begin
        key = '{modifier: MOD_NONE, usage: USAGE_NONE};
        unique case (ch) inside
            [8'h41:8'h5A]: key = '{modifier: SHIFT_MOD, usage: ch - 8'h41 + USAGE_A};
            [8'h61:8'h7A]: key = '{modifier: MOD_NONE,  usage: ch - 8'h61 + USAGE_A};
            [8'h31:8'h39]: key = '{modifier: MOD_NONE,  usage: ch - 8'h31 + USAGE_1};
            8'h30: key = '{modifier: MOD_NONE, usage: USAGE_0};
            8'h20: key = '{modifier: MOD_NONE, usage: USAGE_SPACE};
            8'h0A: key = '{modifier: MOD_NONE, usage: USAGE_ENTER};
            // Shifted symbols sit on the digit row.
            8'h21: key = '{modifier: SHIFT_MOD, usage: 8'h1E};
            8'h40: key = '{modifier: SHIFT_MOD, usage: 8'h1F};
            8'h23: key = '{modifier: SHIFT_MOD, usage: 8'h20};
            8'h24: key = '{modifier: SHIFT_MOD, usage: 8'h21};
            8'h25: key = '{modifier: SHIFT_MOD, usage: 8'h22};
            8'h5E: key = '{modifier: SHIFT_MOD, usage: 8'h23};
            8'h26: key = '{modifier: SHIFT_MOD, usage: 8'h24};
            8'h2A: key = '{modifier: SHIFT_MOD, usage: 8'h25};
            8'h28: key = '{modifier: SHIFT_MOD, usage: 8'h26};
            8'h29: key = '{modifier: SHIFT_MOD, usage: 8'h27};
            8'h2D: key = '{modifier: MOD_NONE, usage: 8'h2D};
            8'h3D: key = '{modifier: MOD_NONE, usage: 8'h2E};
            8'h5B: key = '{modifier: MOD_NONE, usage: 8'h2F};
            8'h5D: key = '{modifier: MOD_NONE, usage: 8'h30};
            8'h5C: key = '{modifier: MOD_NONE, usage: 8'h31};
            8'h3B: key = '{modifier: MOD_NONE, usage: 8'h33};
            8'h27: key = '{modifier: MOD_NONE, usage: 8'h34};
            8'h2C: key = '{modifier: MOD_NONE, usage: 8'h36};
            8'h2E: key = '{modifier: MOD_NONE, usage: 8'h37};
            8'h2F: key = '{modifier: MOD_NONE, usage: 8'h38};
            default: key = '{modifier: MOD_NONE, usage: USAGE_NONE};
        endcase
    end

endmodule

FILE: hdl/ascii_to_hid_keystroke_encoder.sv
// Top level: scan sequencer, held-character window and report output register.
`timescale 1ns / 1ps
`include "ascii_to_hid_keystroke_encoder_defines.svh"

// Channel     Dir  Payload                              Beat
// char_in     in   char_code[7:0], end_of_message       one character
// report_out  out  modifier[1:0], keycode[7:0], last    one HID key report
//
// A character is taken in the idle state, then scanned one window position per scan step
// (up to five), and each key it yields is sent as a press beat and a release beat.
// The keyword compare unit and the key map unit are each shared by every scan step.
// Reset empties the held-character window; no clearing pass is needed.
// A stalled report_out holds the sequencer in place; char_in is ready only when idle.

module ascii_to_hid_keystroke_encoder
    import a2h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    a2h_char_if.sink     char_in,
    a2h_report_if.source report_out
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_PRESS = 4'b0100,
        ST_REL   = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    work_buf_t   work_reg, work_next;
    cnt_t        n_reg, n_next;
    logic        eom_reg, eom_next;
    logic        done_reg, done_next;
    logic        rel_pend_reg, rel_pend_next;
    logic        key_wait_reg, key_wait_next;
    key_t        key_reg, key_next;
    logic        out_valid_reg, out_valid_next;
    mod_t        out_mod_reg, out_mod_next;
    char_t       out_key_reg, out_key_next;
    logic        out_last_reg, out_last_next;

    cls_result_t cls;
    key_t        mapped;
    logic        slot_free;
    logic        last_step;

    a2h_classify u_classify (
        .chars  (work_reg),
        .count  (n_reg),
        .result (cls)
    );

    a2h_keymap u_keymap (
        .ch  (work_reg[0]),
        .key (mapped)
    );

    assign slot_free = !out_valid_reg || report_out.ready;
    assign last_step = (n_reg == cnt_t'(1));

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        n_next         = n_reg;
        eom_next       = eom_reg;
        done_next      = done_reg;
        rel_pend_next  = rel_pend_reg;
        key_wait_next  = key_wait_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !report_out.ready;
        out_mod_next   = out_mod_reg;
        out_key_next   = out_key_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (char_in.valid)
                begin
                    work_next[n_reg[IDX_W-1:0]] = char_in.char_code;
                    n_next        = n_reg + cnt_t'(1);
                    eom_next      = char_in.end_of_message;
                    done_next     = 1'b0;
                    rel_pend_next = 1'b0;
                    key_wait_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cls.kind == CLS_WORD)
                begin
                    key_next      = '{modifier: MOD_NONE, usage: cls.usage};
                    key_wait_next = 1'b1;
                    n_next        = '0;
                    done_next     = 1'b1;
                    state_next    = rel_pend_reg ? ST_REL : ST_PRESS;
                end
                else if ((cls.kind == CLS_PREFIX) && !eom_reg)
                begin
                    // Still a possible keyword: keep the window and wait for more text.
                    state_next = rel_pend_reg ? ST_REL : ST_IDLE;
                end
                else
                begin
                    for (int i = 0; i < WORK_DEPTH - 1; i++)
                    begin
                        work_next[i] = work_reg[i+1];
                    end
                    n_next = n_reg - cnt_t'(1);
                    if (mapped.usage != USAGE_NONE)
                    begin
                        key_next      = mapped;
                        key_wait_next = 1'b1;
                        done_next     = last_step;
                        state_next    = rel_pend_reg ? ST_REL : ST_PRESS;
                    end
                    else if (last_step)
                    begin
                        state_next = rel_pend_reg ? ST_REL : ST_IDLE;
                    end
                end
            end
            ST_PRESS:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_mod_next   = key_reg.modifier;
                    out_key_next   = key_reg.usage;
                    out_last_next  = 1'b0;
                    key_wait_next  = 1'b0;
                    rel_pend_next  = 1'b1;
                    state_next     = done_reg ? ST_REL : ST_SCAN;
                end
            end
            ST_REL:
            begin
                // The release is the final beat unless another key is already waiting.
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_mod_next   = MOD_NONE;
                    out_key_next   = USAGE_NONE;
                    out_last_next  = !key_wait_reg;
                    rel_pend_next  = 1'b0;
                    state_next     = key_wait_reg ? ST_PRESS : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            eom_reg       <= 1'b0;
            done_reg      <= 1'b0;
            rel_pend_reg  <= 1'b0;
            key_wait_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            eom_reg       <= eom_next;
            done_reg      <= done_next;
            rel_pend_reg  <= rel_pend_next;
            key_wait_reg  <= key_wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        key_reg      <= key_next;
        out_mod_reg  <= out_mod_next;
        out_key_reg  <= out_key_next;
        out_last_reg <= out_last_next;
    end

    assign char_in.ready       = (state_reg == ST_IDLE);
    assign report_out.valid    = out_valid_reg;
    assign report_out.modifier = out_mod_reg;
    assign report_out.keycode  = out_key_reg;
    assign report_out.last     = out_last_reg;

    `A2H_ASSERT_NOW(a_idle_window_bound, char_in.ready, n_reg <= cnt_t'(PENDING_DEPTH), "held window exceeds the longest keyword prefix while idle")
    `A2H_ASSERT_NOW(a_scan_not_empty, state_reg == ST_SCAN, n_reg != '0, "scan step entered with an empty window")
    `A2H_ASSERT_NOW(a_last_is_release, report_out.valid && report_out.last, report_out.keycode == USAGE_NONE && report_out.modifier == MOD_NONE, "final report of a character is not a release")
    `A2H_ASSERT_NOW(a_shift_has_key, report_out.valid && report_out.modifier != MOD_NONE, report_out.keycode != USAGE_NONE, "shift report without a key usage")
    `A2H_ASSERT_NEXT(a_accept_starts_scan, char_in.valid && char_in.ready, state_reg == ST_SCAN, "accepted character did not start a scan")

endmodule

FILE: bench/ascii_to_hid_keystroke_encoder_tb.sv
// Self-checking testbench for the ASCII to HID keystroke encoder.
`timescale 1ns / 1ps

module ascii_to_hid_keystroke_encoder_tb;
    import a2h_pkg::*;

    localparam int HOLD_DEPTH    = 4;
    localparam int RANDOM_ITEMS  = 405;
    localparam int SETTLE_CYCLES = 40;
    localparam int PAUSE_EVERY   = 9;

    localparam char_t ARROW_UP    = 8'h52;
    localparam char_t ARROW_DOWN  = 8'h51;
    localparam char_t ARROW_LEFT  = 8'h50;
    localparam char_t ARROW_RIGHT = 8'h4F;

    typedef enum int {FLOW_FREE, FLOW_COIN, FLOW_SPARSE, FLOW_CADENCE} flow_t;

    typedef struct packed {
        mod_t  modifier;
        char_t keycode;
        logic  last;
    } hid_report_t;

    // One row of the directed script. When typed is set, the row carries its own
    // answer: one key (press and release) or nothing at all when keycode is zero.
    typedef struct packed {
        char_t code;
        logic  eom;
        logic  typed;
        mod_t  modifier;
        char_t keycode;
    } step_t;

    logic clk;
    logic rst_n;

    a2h_char_if   char_ch ();
    a2h_report_if report_ch ();

    ascii_to_hid_keystroke_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_ch),
        .report_out (report_ch)
    );

    char_t       held_chars [HOLD_DEPTH];
    int          held_count;
    hid_report_t step_reports [$];
    hid_report_t reports_owed [$];
    step_t       script [$];
    char_t       message [$];
    int          burst_left;
    int          mismatches;
    int          reports_seen;
    int          chars_sent;
    int          messages_sent;
    int          arrows_typed;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic string keyword_text(input int w);
        case (w)
            0:       return "UP";
            1:       return "DOWN";
            2:       return "LEFT";
            default: return "RIGHT";
        endcase
    endfunction

    function automatic char_t arrow_usage(input int w);
        case (w)
            0:       return ARROW_UP;
            1:       return ARROW_DOWN;
            2:       return ARROW_LEFT;
            default: return ARROW_RIGHT;
        endcase
    endfunction

    function automatic cls_kind_t classify(input char_t win [HOLD_DEPTH+1], input int n,
                                           output char_t usage);
        cls_kind_t kind;
        string     word;
        bit        fits;
        kind  = CLS_NONE;
        usage = USAGE_NONE;
        for (int w = 0; w < 4; w++)
        begin
            word = keyword_text(w);
            fits = (n <= word.len());
            for (int i = 0; fits && i < n; i++)
                if (win[i] != char_t'(word[i]))
                    fits = 1'b0;
            if (fits)
            begin
                if (n == word.len())
                begin
                    usage = arrow_usage(w);
                    return CLS_WORD;
                end
                kind = CLS_PREFIX;
            end
        end
        return kind;
    endfunction

    function automatic char_t map_key(input char_t c, output mod_t m);
        m = MOD_NONE;
        if (c >= "A" && c <= "Z")
        begin
            m = SHIFT_MOD;
            return USAGE_A + (c - "A");
        end
        if (c >= "a" && c <= "z")
            return USAGE_A + (c - "a");
        if (c >= "1" && c <= "9")
            return USAGE_1 + (c - "1");
        case (c)
            "0":  return USAGE_0;
            " ":  return USAGE_SPACE;
            "\n": return USAGE_ENTER;
            "-":  return 8'h2D;
            "=":  return 8'h2E;
            "[":  return 8'h2F;
            "]":  return 8'h30;
            "\\": return 8'h31;
            ";":  return 8'h33;
            "'":  return 8'h34;
            ",":  return 8'h36;
            ".":  return 8'h37;
            "/":  return 8'h38;
            default: ;
        endcase
        // Shifted symbols sit on the digit row, from 1 through 0.
        m = SHIFT_MOD;
        case (c)
            "!": return USAGE_1;
            "@": return USAGE_1 + 8'd1;
            "#": return USAGE_1 + 8'd2;
            "$": return USAGE_1 + 8'd3;
            "%": return USAGE_1 + 8'd4;
            "^": return USAGE_1 + 8'd5;
            "&": return USAGE_1 + 8'd6;
            "*": return USAGE_1 + 8'd7;
            "(": return USAGE_1 + 8'd8;
            ")": return USAGE_0;
            default: ;
        endcase
        m = MOD_NONE;
        return USAGE_NONE;
    endfunction

    function automatic void add_key(input mod_t m, input char_t usage);
        hid_report_t r;
        r.modifier = m;
        r.keycode  = usage;
        r.last     = 1'b0;
        step_reports.push_back(r);
        r.modifier = MOD_NONE;
        r.keycode  = USAGE_NONE;
        step_reports.push_back(r);
    endfunction

    // Works out the reports one character causes and updates the held window.
    function automatic void encode_char(input char_t c, input logic eom);
        char_t     win [HOLD_DEPTH+1];
        char_t     usage;
        mod_t      m;
        cls_kind_t kind;
        int        n;
        bit        holding;
        for (int i = 0; i < held_count; i++)
            win[i] = held_chars[i];
        win[held_count] = c;
        n       = held_count + 1;
        holding = 1'b0;
        step_reports.delete();
        while (n > 0 && !holding)
        begin
            kind = classify(win, n, usage);
            if (kind == CLS_WORD)
            begin
                add_key(MOD_NONE, usage);
                arrows_typed++;
                n = 0;
            end
            else if (kind == CLS_PREFIX && !eom)
                holding = 1'b1;
            else
            begin
                // The window cannot become a keyword: the oldest character goes out as is.
                usage = map_key(win[0], m);
                if (usage != USAGE_NONE)
                    add_key(m, usage);
                for (int i = 1; i < n; i++)
                    win[i-1] = win[i];
                n--;
            end
        end
        for (int i = 0; i < n; i++)
            held_chars[i] = win[i];
        held_count = n;
    endfunction

    function automatic void commit_reports();
        hid_report_t r;
        foreach (step_reports[i])
        begin
            r      = step_reports[i];
            r.last = (i == step_reports.size() - 1);
            reports_owed.push_back(r);
        end
    endfunction

    function automatic step_t make_step(input char_t code, input logic eom, input logic typed,
                                        input mod_t m, input char_t usage);
        step_t s;
        s.code     = code;
        s.eom      = eom;
        s.typed    = typed;
        s.modifier = m;
        s.keycode  = usage;
        return s;
    endfunction

    function automatic char_t printable_char();
        if ($urandom_range(0, 15) == 0)
            return "\n";
        return char_t'($urandom_range(8'h20, 8'h7E));
    endfunction

    task automatic log_mismatch(input string note);
        mismatches++;
        $display("[%0t] MISMATCH at report %0d: %s", $realtime, reports_seen, note);
    endtask

    // Returns at the rising edge where the character beat is taken.
    task automatic send_char(input char_t c, input logic eom);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                char_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        char_ch.valid          <= 1'b1;
        char_ch.char_code      <= c;
        char_ch.end_of_message <= eom;
        do
            @(posedge clk);
        while (!char_ch.ready);
        burst_left--;
        chars_sent++;
        if (eom)
            messages_sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        char_ch.valid <= 1'b0;
        while (reports_owed.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        step_t row;
        string word;
        int    pick;
        int    cut;
        rst_n                  = 1'b0;
        char_ch.valid          = 1'b0;
        char_ch.char_code      = '0;
        char_ch.end_of_message = 1'b0;
        held_count             = 0;
        burst_left             = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        script.push_back(make_step("a",    1'b0, 1'b1, MOD_NONE,  USAGE_A));
        script.push_back(make_step("Z",    1'b0, 1'b1, SHIFT_MOD, 8'h1D));
        script.push_back(make_step("0",    1'b0, 1'b1, MOD_NONE,  USAGE_0));
        script.push_back(make_step(" ",    1'b0, 1'b1, MOD_NONE,  USAGE_SPACE));
        script.push_back(make_step("\n",   1'b0, 1'b1, MOD_NONE,  USAGE_ENTER));
        script.push_back(make_step("!",    1'b0, 1'b1, SHIFT_MOD, USAGE_1));
        script.push_back(make_step(")",    1'b0, 1'b1, SHIFT_MOD, USAGE_0));
        script.push_back(make_step("-",    1'b0, 1'b1, MOD_NONE,  8'h2D));
        script.push_back(make_step("/",    1'b0, 1'b1, MOD_NONE,  8'h38));
        script.push_back(make_step(8'h00,  1'b0, 1'b1, MOD_NONE,  USAGE_NONE));
        script.push_back(make_step("~",    1'b0, 1'b1, MOD_NONE,  USAGE_NONE));
        script.push_back(make_step(8'hFF,  1'b1, 1'b1, MOD_NONE,  USAGE_NONE));
        script.push_back(make_step("U",    1'b0, 1'b0, MOD_NONE,  USAGE_NONE));
        script.push_back(make_step("P",    1'b0, 1'b0, MOD_NONE,  USAGE_NONE));
        script.push_back(make_step("D",    1'b0, 1'b0, MOD_NONE,  USAGE_NONE));
        script.push_back(make_step("O",    1'b0, 1'b0, MOD_NONE,  USAGE_NONE));
        script.push_back(make_step("W",    1'b0, 1'b0, MOD_NONE,  USAGE_NONE));
        script.push_back(make_step("N",    1'b0, 1'b0, MOD_NONE,  USAGE_NONE));
        // A keyword prefix cut by the end mark comes out as four shifted letters.
        script.push_back(make_step("R",    1'b0, 1'b0, MOD_NONE,  USAGE_NONE));
        script.push_back(make_step("I",    1'b0, 1'b0, MOD_NONE,  USAGE_NONE));
        script.push_back(make_step("G",    1'b0, 1'b0, MOD_NONE,  USAGE_NONE));
        script.push_back(make_step("H",    1'b0, 1'b0, MOD_NONE,  USAGE_NONE));
        script.push_back(make_step("\\",   1'b1, 1'b0, MOD_NONE,  USAGE_NONE));
        script.push_back(make_step("U",    1'b1, 1'b0, MOD_NONE,  USAGE_NONE));

        foreach (script[i])
        begin
            row = script[i];
            send_char(row.code, row.eom);
            encode_char(row.code, row.eom);
            if (row.typed)
            begin
                step_reports.delete();
                if (row.keycode != USAGE_NONE)
                    add_key(row.modifier, row.keycode);
            end
            commit_reports();
        end
        hold_until_drained();

        // Messages are built mostly from keywords, whole or broken, mixed with plain text.
        while (chars_sent < script.size() + RANDOM_ITEMS)
        begin
            message.delete();
            repeat ($urandom_range(1, 4))
            begin
                word = keyword_text($urandom_range(0, 3));
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    for (int i = 0; i < word.len(); i++)
                        message.push_back(char_t'(word[i]));
                end
                else if (pick < 60)
                begin
                    cut = $urandom_range(1, word.len() - 1);
                    for (int i = 0; i < cut; i++)
                        message.push_back(char_t'(word[i]));
                    if (pick < 52)
                        message.push_back(printable_char());
                end
                else if (pick < 85)
                begin
                    repeat ($urandom_range(1, 4))
                        message.push_back(printable_char());
                end
                else
                    message.push_back(char_t'($urandom_range(0, 255)));
            end
            foreach (message[i])
            begin
                send_char(message[i], i == message.size() - 1);
                encode_char(message[i], i == message.size() - 1);
                commit_reports();
            end
            if (messages_sent % PAUSE_EVERY == 0)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d characters in %0d messages, %0d arrow keywords among them.",
                 chars_sent, messages_sent, arrows_typed);
        $display("Checked %0d key report beats under random sender gaps and receiver stalls.",
                 reports_seen);
        if (mismatches == 0 && reports_owed.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        flow_t flow;
        int    flow_left;
        int    tick;
        report_ch.ready = 1'b0;
        flow            = FLOW_FREE;
        flow_left       = 0;
        tick            = 0;
        forever
        begin
            @(negedge clk);
            if (flow_left == 0)
            begin
                flow      = flow_t'($urandom_range(0, 3));
                flow_left = $urandom_range(16, 96);
            end
            flow_left--;
            tick++;
            case (flow)
                FLOW_FREE:   report_ch.ready <= 1'b1;
                FLOW_COIN:   report_ch.ready <= 1'($urandom_range(0, 1));
                FLOW_SPARSE: report_ch.ready <= ($urandom_range(0, 3) == 0);
                default:     report_ch.ready <= (tick % 3 != 2);
            endcase
        end
    end

    always @(posedge clk)
    begin
        hid_report_t want;
        if (rst_n && report_ch.valid && report_ch.ready)
        begin
            reports_seen++;
            if (reports_owed.size() == 0)
                log_mismatch($sformatf("report beat with none owed (mod %0d key 0x%02h)",
                                       report_ch.modifier, report_ch.keycode));
            else
            begin
                want = reports_owed.pop_front();
                if (report_ch.modifier !== want.modifier)
                    log_mismatch($sformatf("modifier got %0d want %0d",
                                           report_ch.modifier, want.modifier));
                if (report_ch.keycode !== want.keycode)
                    log_mismatch($sformatf("keycode got 0x%02h want 0x%02h",
                                           report_ch.keycode, want.keycode));
                if (report_ch.last !== want.last)
                    log_mismatch($sformatf("last got %0d want %0d",
                                           report_ch.last, want.last));
            end
        end
    end

    initial
    begin
        #6_000_000;
        $display("Timed out with %0d report beats still owed.", reports_owed.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
